/* rtl/core/gmd_pkg.sv */
package gmd_pkg;

	localparam int GRID_DIM   = 8;
	localparam int COORD_W    = 3;
	localparam int CELL_COUNT = GRID_DIM * GRID_DIM;
	localparam int CELL_W     = 6;
	localparam int STACK_MAX  = 64;
	localparam int DEPTH_W    = 7;
	localparam int SIDX_W     = 6;
	localparam int TRIED_W    = 3;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [1:0]         kind_t;
	typedef logic [CELL_W-1:0]  cell_idx_t;

	localparam kind_t KIND_ROAD  = 2'd0;
	localparam kind_t KIND_WALL  = 2'd1;
	localparam kind_t KIND_START = 2'd2;
	localparam kind_t KIND_GOAL  = 2'd3;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_START_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 1'b1;

	localparam coord_t START_X_RST = 3'd2;
	localparam coord_t START_Y_RST = 3'd3;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	// all four directions tried
	localparam logic [TRIED_W-1:0] TRIED_DONE = 3'd4;

	typedef struct packed {
		coord_t              col;
		coord_t              row;
		logic [TRIED_W-1:0]  tried;
	} stack_ent_t;

	typedef struct packed {
		logic load_cell;
		logic init;
		logic clear;
		logic mark_top;
		logic rd_nbr;
		logic skip;
		logic push;
		logic pop;
		logic load_top;
		logic flush;
		logic next_idx;
		logic emit;
		logic emit_nopath;
	} gmd_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  start_ok;
		logic  nbr_ok;
		logic  nbr_seen;
		logic  clr_done;
		logic  dir_done;
		logic  depth_one;
		logic  out_fire;
		logic  out_last;
	} gmd_sts_t;

	function automatic cell_idx_t cell_at(coord_t col, coord_t row);
		return CELL_W'(row) * CELL_W'(GRID_DIM) + CELL_W'(col);
	endfunction

endpackage

/* rtl/core/gmd_chan_if.sv */
interface gmd_in_if;
	import gmd_pkg::*;

	logic   valid;
	logic   ready;
	logic   op;
	coord_t cell_x;
	coord_t cell_y;
	kind_t  cell_kind;

	modport source (output valid, output op, output cell_x, output cell_y, output cell_kind,
		input ready);
	modport sink (input valid, input op, input cell_x, input cell_y, input cell_kind,
		output ready);
endinterface

interface gmd_out_if;
	import gmd_pkg::*;

	logic   valid;
	logic   ready;
	coord_t route_x;
	coord_t route_y;
	logic   found;
	logic   last;

	modport source (output valid, output route_x, output route_y, output found, output last,
		input ready);
	modport sink (input valid, input route_x, input route_y, input found, input last,
		output ready);
endinterface

/* rtl/core/gmd_dpath.sv */
module gmd_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gmd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [gmd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  gmd_pkg::coord_t                  in_cell_x,
	input  gmd_pkg::coord_t                  in_cell_y,
	input  gmd_pkg::kind_t                   in_cell_kind,
	input  gmd_pkg::gmd_cmd_t                cmd,
	output gmd_pkg::gmd_sts_t                sts,
	input  logic                             out_ready,
	output logic                             out_valid,
	output gmd_pkg::coord_t                  route_x,
	output gmd_pkg::coord_t                  route_y,
	output logic                             found,
	output logic                             last
);
	import gmd_pkg::*;

	coord_t start_x_q, start_y_q;

	// maze map: memory plus per-cell written flags (unwritten cells read as road)
	kind_t                 maze_mem [CELL_COUNT];
	logic [CELL_COUNT-1:0] maze_vld_q;
	kind_t                 maze_rd_q;
	logic                  maze_vld_rd_q;

	// visited flags: cleared by a pass over all cells at the start of each search
	logic                  vis_mem [CELL_COUNT];
	logic                  vis_rd_q;
	logic                  vis_we, vis_wdata;
	cell_idx_t             vis_waddr;

	stack_ent_t stack_mem [STACK_MAX];
	stack_ent_t stk_rd_q;

	coord_t               top_col_q, top_row_q;
	logic [TRIED_W-1:0]   top_tried_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic [SIDX_W-1:0]    idx_q;

	logic                 out_valid_q;
	coord_t               route_x_q, route_y_q;
	logic                 found_q, last_q;

	logic [COORD_W:0]     nc, nr;
	logic                 nbr_in;
	cell_idx_t            nbr_cell, top_cell, start_cell, load_cell_idx, maze_raddr;
	logic                 start_ok, load_in_grid, idx_last;
	logic [DEPTH_W-1:0]   depth_m1, depth_m2;
	logic [SIDX_W-1:0]    stk_raddr, stk_waddr;
	stack_ent_t           stk_wdata;
	logic                 stk_we;

	always_comb begin
		nc = {1'b0, top_col_q};
		nr = {1'b0, top_row_q};
		case (top_tried_q[1:0])
			DIR_UP:    nr = nr - (COORD_W+1)'(1);
			DIR_LEFT:  nc = nc - (COORD_W+1)'(1);
			DIR_RIGHT: nc = nc + (COORD_W+1)'(1);
			DIR_DOWN:  nr = nr + (COORD_W+1)'(1);
			default:   nr = nr;
		endcase
	end

	assign nbr_in        = (nc < (COORD_W+1)'(GRID_DIM)) && (nr < (COORD_W+1)'(GRID_DIM));
	assign nbr_cell      = cell_at(nc[COORD_W-1:0], nr[COORD_W-1:0]);
	assign top_cell      = cell_at(top_col_q, top_row_q);
	assign start_cell    = cell_at(start_x_q, start_y_q);
	assign start_ok      = ({1'b0, start_x_q} < (COORD_W+1)'(GRID_DIM)) &&
	                       ({1'b0, start_y_q} < (COORD_W+1)'(GRID_DIM));
	assign load_in_grid  = ({1'b0, in_cell_x} < (COORD_W+1)'(GRID_DIM)) &&
	                       ({1'b0, in_cell_y} < (COORD_W+1)'(GRID_DIM));
	assign load_cell_idx = cell_at(in_cell_x, in_cell_y);
	assign maze_raddr    = cmd.rd_nbr ? nbr_cell : top_cell;

	assign vis_we    = cmd.clear || cmd.mark_top || cmd.push;
	assign vis_waddr = cmd.clear ? cell_idx_t'(idx_q) : (cmd.push ? nbr_cell : top_cell);
	assign vis_wdata = !cmd.clear;

	assign depth_m1  = depth_q - DEPTH_W'(1);
	assign depth_m2  = depth_q - DEPTH_W'(2);
	assign idx_last  = {1'b0, idx_q} == depth_m1;
	assign stk_raddr = cmd.pop ? depth_m2[SIDX_W-1:0] : idx_q;
	assign stk_waddr = depth_m1[SIDX_W-1:0];
	assign stk_we    = cmd.push || cmd.flush;

	always_comb begin
		stk_wdata.col   = top_col_q;
		stk_wdata.row   = top_row_q;
		stk_wdata.tried = cmd.push ? top_tried_q + TRIED_W'(1) : top_tried_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= START_X_RST;
			start_y_q <= START_Y_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_START_X: start_x_q <= cfg_data;
				CFG_START_Y: start_y_q <= cfg_data;
				default:     start_x_q <= start_x_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_cell && load_in_grid)
			maze_mem[load_cell_idx] <= in_cell_kind;
		maze_rd_q <= maze_mem[maze_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maze_vld_q    <= '0;
			maze_vld_rd_q <= 1'b0;
		end else begin
			if (cmd.load_cell && load_in_grid)
				maze_vld_q[load_cell_idx] <= 1'b1;
			maze_vld_rd_q <= maze_vld_q[maze_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (vis_we)
			vis_mem[vis_waddr] <= vis_wdata;
		vis_rd_q <= vis_mem[maze_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stack_mem[stk_waddr] <= stk_wdata;
		stk_rd_q <= stack_mem[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_col_q   <= '0;
			top_row_q   <= '0;
			top_tried_q <= '0;
			depth_q     <= '0;
			idx_q       <= '0;
		end else begin
			if (cmd.init) begin
				top_col_q   <= start_x_q;
				top_row_q   <= start_y_q;
				top_tried_q <= '0;
				depth_q     <= start_ok ? DEPTH_W'(1) : '0;
				idx_q       <= '0;
			end
			if (cmd.skip)
				top_tried_q <= top_tried_q + TRIED_W'(1);
			if (cmd.push) begin
				top_col_q   <= nc[COORD_W-1:0];
				top_row_q   <= nr[COORD_W-1:0];
				top_tried_q <= '0;
				depth_q     <= depth_q + DEPTH_W'(1);
			end
			if (cmd.pop)
				depth_q <= depth_m1;
			if (cmd.load_top) begin
				top_col_q   <= stk_rd_q.col;
				top_row_q   <= stk_rd_q.row;
				top_tried_q <= stk_rd_q.tried;
			end
			if (cmd.flush)
				idx_q <= '0;
			if (cmd.next_idx || cmd.clear)
				idx_q <= idx_q + SIDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit || cmd.emit_nopath)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			route_x_q <= stk_rd_q.col;
			route_y_q <= stk_rd_q.row;
			found_q   <= 1'b1;
			last_q    <= idx_last;
		end else if (cmd.emit_nopath) begin
			route_x_q <= start_x_q;
			route_y_q <= start_y_q;
			found_q   <= 1'b0;
			last_q    <= 1'b1;
		end
	end

	always_comb begin
		sts.kind      = maze_vld_rd_q ? maze_rd_q : KIND_ROAD;
		sts.start_ok  = start_ok;
		sts.nbr_ok    = nbr_in && (depth_q != DEPTH_W'(STACK_MAX));
		sts.nbr_seen  = vis_rd_q;
		sts.clr_done  = idx_q == SIDX_W'(CELL_COUNT - 1);
		sts.dir_done  = top_tried_q == TRIED_DONE;
		sts.depth_one = depth_q == DEPTH_W'(1);
		sts.out_fire  = out_valid_q && out_ready;
		sts.out_last  = last_q;
	end

	assign out_valid = out_valid_q;
	assign route_x   = route_x_q;
	assign route_y   = route_y_q;
	assign found     = found_q;
	assign last      = last_q;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> depth_q != DEPTH_W'(STACK_MAX))
		else $error("push onto a full stack");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> depth_q != '0)
		else $error("pop from an empty stack");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.emit_nopath) |-> !out_valid_q)
		else $error("result overwritten before it was taken");

	a_push_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> nbr_in)
		else $error("push of a neighbor outside the grid");

endmodule

/* rtl/core/gmd_ctrl.sv */
module gmd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	output gmd_pkg::gmd_cmd_t  cmd,
	input  gmd_pkg::gmd_sts_t  sts
);
	import gmd_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_TOP   = 4'd1;
	localparam logic [3:0] S_GOAL  = 4'd2;
	localparam logic [3:0] S_PROBE = 4'd3;
	localparam logic [3:0] S_KIND  = 4'd4;
	localparam logic [3:0] S_POPW  = 4'd5;
	localparam logic [3:0] S_FLUSH = 4'd6;
	localparam logic [3:0] S_RD    = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;
	localparam logic [3:0] S_HOLD  = 4'd9;
	localparam logic [3:0] S_CLR   = 4'd10;

	logic [3:0] state_q, state_d;
	logic       accept;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_op == OP_SEARCH) begin
						cmd.init = 1'b1;
						if (sts.start_ok) begin
							state_d = S_CLR;
						end else begin
							cmd.emit_nopath = 1'b1;
							state_d         = S_HOLD;
						end
					end else begin
						cmd.load_cell = 1'b1;
					end
				end
			end
			S_CLR: begin
				cmd.clear = 1'b1;
				if (sts.clr_done)
					state_d = S_TOP;
			end
			S_TOP: begin
				cmd.mark_top = 1'b1;
				state_d      = S_GOAL;
			end
			S_GOAL: state_d = (sts.kind == KIND_GOAL) ? S_FLUSH : S_PROBE;
			S_PROBE: begin
				cmd.rd_nbr = 1'b1;
				if (sts.dir_done) begin
					cmd.pop = 1'b1;
					if (sts.depth_one) begin
						cmd.emit_nopath = 1'b1;
						state_d         = S_HOLD;
					end else begin
						state_d = S_POPW;
					end
				end else if (sts.nbr_ok) begin
					state_d = S_KIND;
				end else begin
					cmd.skip = 1'b1;
				end
			end
			S_KIND: begin
				// neighbor kind and visited flag are back; start and wall cells are never entered
				if (!sts.nbr_seen && (sts.kind == KIND_ROAD || sts.kind == KIND_GOAL)) begin
					cmd.push = 1'b1;
					state_d  = (sts.kind == KIND_GOAL) ? S_FLUSH : S_PROBE;
				end else begin
					cmd.skip = 1'b1;
					state_d  = S_PROBE;
				end
			end
			S_POPW: begin
				cmd.load_top = 1'b1;
				state_d      = S_PROBE;
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = S_RD;
			end
			S_RD: state_d = S_EMIT;
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = S_HOLD;
			end
			S_HOLD: begin
				if (sts.out_fire) begin
					if (sts.out_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.next_idx = 1'b1;
						state_d      = S_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	a_push_from_kind: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> state_q == S_KIND && $past(state_q) == S_PROBE)
		else $error("push without a neighbor probe");

	a_hold_leads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD && sts.out_fire && !sts.out_last) |=> state_q == S_RD)
		else $error("path readout did not continue");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD && sts.out_fire && sts.out_last) |=> in_ready)
		else $error("block not ready after final result");

endmodule

/* rtl/core/grid_maze_depth_first_path.sv */
// Grid maze solver, depth-first walk on an 8x8 map of 2-bit cell kinds.
// Channels: in_ch carries requests (op, cell_x, cell_y, cell_kind); out_ch
// carries results (route_x, route_y, found, last). Both use valid/ready; a
// request or result moves on a clock edge with valid and ready both high.
// Config: cfg_we/cfg_idx/cfg_data write start_x (index 0) or start_y (index 1).
// A load request (op 0) writes one cell and keeps in_ch.ready high; the next
// request may follow in the next cycle.
// A search request (op 1) holds in_ch.ready low until its last result is taken.
// It first clears the visited flags one cell per cycle, then marks and checks
// the start cell. Each walk step reads the maze and visited flags, then tests
// them; an off-grid or stack-full direction is simply skipped, and a dead end
// reads the stack, then restores the cell below as the new top.
// Readout then gives each path cell from the stack as one result; the
// path runs from start to goal with last set on the goal cell. With no path a
// single result with found clear and the start cell is given.
// A stalled receiver simply holds the search in readout; the result register
// keeps its contents until taken.
// Reset: start = (2,3), maze reads as all road; visited flags need no reset.
module grid_maze_depth_first_path (
	input  logic                            clk,
	input  logic                            arst_n,
	gmd_in_if.sink                          in_ch,
	gmd_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [gmd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [gmd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import gmd_pkg::*;

	gmd_cmd_t cmd;
	gmd_sts_t sts;

	gmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_op    (in_ch.op),
		.in_ready (in_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	gmd_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.in_cell_x    (in_ch.cell_x),
		.in_cell_y    (in_ch.cell_y),
		.in_cell_kind (in_ch.cell_kind),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (out_ch.ready),
		.out_valid    (out_ch.valid),
		.route_x      (out_ch.route_x),
		.route_y      (out_ch.route_y),
		.found        (out_ch.found),
		.last         (out_ch.last)
	);

endmodule
